// File: src/tfn_pkg.sv
// Shared constants and pipeline tag types for the triangle face normal unit.
// No dependencies.
package tfn_pkg;

  // Normalized magnitude width and output fraction bits
  localparam int NORM_BITS = 30;
  localparam int FRAC_OUT  = 14;

  // Derived fixed widths behind the normalization point
  localparam int SQ_W   = 2 * NORM_BITS;             // one squared magnitude
  localparam int SUM_W  = 2 * NORM_BITS + 2;         // sum of three squares
  localparam int ROOT_W = NORM_BITS + 1;             // floor(sqrt(sum))
  localparam int NUM_W  = NORM_BITS + FRAC_OUT + 1;  // rounded dividend
  localparam int QUO_W  = FRAC_OUT + 1;              // quotient, up to 2^14
  localparam int OUT_W  = 16;                        // Q1.14 output

  // Tag carried through the square root pipe
  typedef struct packed {
    logic                          degen;
    logic [2:0]                    neg;
    logic [2:0][NORM_BITS-1:0]     mag;
  } norm_tag_t;

  // Tag carried through the divider pipe
  typedef struct packed {
    logic       degen;
    logic [2:0] neg;
  } sign_tag_t;

endpackage

// File: src/triangle_face_normal_unit.sv
// Triangle face normal: edges, cross product, normalize, pipelined.
// Depends on tfn_pkg.
//
// One triangle is taken per cycle: busy is always low, so every start pulse
// is a beat. Each result appears on the out_ ports for one cycle with
// out_valid high, after its start beat has passed the registered stages in
// order: edges, products, cross, magnitudes, leading-bit search (top byte
// group, then within group), normalize, squares, sum, square root (one root
// bit per stage), dividend, divide (one quotient bit per stage), output. The
// receiver cannot stall the pipe. A zero-area triangle gives a zero normal with
// out_degenerate set.
module triangle_face_normal_unit #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_y,
  input  logic signed [COORD_WIDTH-1:0] in_a_z,
  input  logic signed [COORD_WIDTH-1:0] in_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_y,
  input  logic signed [COORD_WIDTH-1:0] in_b_z,
  input  logic signed [COORD_WIDTH-1:0] in_c_x,
  input  logic signed [COORD_WIDTH-1:0] in_c_y,
  input  logic signed [COORD_WIDTH-1:0] in_c_z,
  output logic                          out_valid,
  output logic signed [15:0]            out_normal_x,
  output logic signed [15:0]            out_normal_y,
  output logic signed [15:0]            out_normal_z,
  output logic                          out_degenerate
);

  localparam int W    = COORD_WIDTH;
  localparam int ESH  = (W > 30) ? W - 30 : 0;      // edge pre-shift
  localparam int EW   = ((W > 30) ? 30 : W) + 1;    // edge width
  localparam int PW   = 2 * EW;                     // product width
  localparam int CW   = 2 * EW + 1;                 // cross width
  localparam int MW   = 2 * EW;                     // cross magnitude width
  localparam int KW   = $clog2(MW + 1);             // bit length width
  localparam int NG   = (MW + 7) / 8;               // byte groups to search
  localparam int GW   = $clog2(NG);
  localparam int XW   = MW + tfn_pkg::NORM_BITS;    // shifter width
  localparam int NB   = tfn_pkg::NORM_BITS;
  localparam int RW   = tfn_pkg::ROOT_W;
  localparam int QW   = tfn_pkg::QUO_W;
  localparam int NW   = tfn_pkg::NUM_W;
  localparam int SW   = tfn_pkg::SUM_W;
  localparam int OW   = tfn_pkg::OUT_W;

  assign busy = 1'b0;

  // ---------------------------------------------------------------- edges
  logic signed [W-1:0] va [3];
  logic signed [W-1:0] vb [3];
  logic signed [W-1:0] vc [3];
  assign va[0] = in_a_x;  assign va[1] = in_a_y;  assign va[2] = in_a_z;
  assign vb[0] = in_b_x;  assign vb[1] = in_b_y;  assign vb[2] = in_b_z;
  assign vc[0] = in_c_x;  assign vc[1] = in_c_y;  assign vc[2] = in_c_z;

  logic              e_vld_r;
  logic signed [EW-1:0] ab_r [3];
  logic signed [EW-1:0] ac_r [3];
  logic signed [EW-1:0] ab_nxt [3];
  logic signed [EW-1:0] ac_nxt [3];

  // floor-shift each edge when the coordinates are wider than 30 bits
  always_comb begin
    logic signed [W:0] dab;
    logic signed [W:0] dac;
    logic signed [W:0] sab;
    logic signed [W:0] sac;
    for (int j = 0; j < 3; j++) begin
      dab = (W+1)'(va[j]) - (W+1)'(vb[j]);
      dac = (W+1)'(va[j]) - (W+1)'(vc[j]);
      sab = dab >>> ESH;
      sac = dac >>> ESH;
      ab_nxt[j] = sab[EW-1:0];
      ac_nxt[j] = sac[EW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else begin
      e_vld_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      ab_r[j] <= ab_nxt[j];
      ac_r[j] <= ac_nxt[j];
    end
  end

  // ------------------------------------------------------------- products
  logic                 p_vld_r;
  logic signed [PW-1:0] p_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p_r[0] <= ab_r[1] * ac_r[2];
    p_r[1] <= ab_r[2] * ac_r[1];
    p_r[2] <= ab_r[2] * ac_r[0];
    p_r[3] <= ab_r[0] * ac_r[2];
    p_r[4] <= ab_r[0] * ac_r[1];
    p_r[5] <= ab_r[1] * ac_r[0];
  end

  // ---------------------------------------------------------------- cross
  logic                 c_vld_r;
  logic signed [CW-1:0] cr_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      cr_r[j] <= CW'(p_r[2*j]) - CW'(p_r[2*j+1]);
    end
  end

  // ----------------------------------------------------------- magnitudes
  logic          m_vld_r;
  logic          m_degen_r;
  logic [2:0]    m_neg_r;
  logic [MW-1:0] m_mag_r [3];
  logic [MW-1:0] m_mag_nxt [3];

  always_comb begin
    logic [CW-1:0] t;
    for (int j = 0; j < 3; j++) begin
      t = cr_r[j][CW-1] ? (~cr_r[j] + CW'(1)) : cr_r[j];
      m_mag_nxt[j] = t[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    m_degen_r <= (cr_r[0] == '0) && (cr_r[1] == '0) && (cr_r[2] == '0);
    for (int j = 0; j < 3; j++) begin
      m_neg_r[j] <= cr_r[j][CW-1];
      m_mag_r[j] <= m_mag_nxt[j];
    end
  end

  // ------------------------------------------- leading bit: top byte group
  logic          g_vld_r;
  logic          g_degen_r;
  logic [2:0]    g_neg_r;
  logic [MW-1:0] g_mag_r [3];
  logic [GW-1:0] g_sel_r;
  logic [7:0]    g_byte_r;
  logic [GW-1:0] g_sel_nxt;
  logic [7:0]    g_byte_nxt;

  always_comb begin
    logic [NG*8-1:0] bigp;
    bigp = (NG*8)'(m_mag_r[0] | m_mag_r[1] | m_mag_r[2]);
    g_sel_nxt  = '0;
    g_byte_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      if (|bigp[g*8 +: 8]) begin
        g_sel_nxt  = GW'(g);
        g_byte_nxt = bigp[g*8 +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else begin
      g_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    g_degen_r <= m_degen_r;
    g_neg_r   <= m_neg_r;
    g_sel_r   <= g_sel_nxt;
    g_byte_r  <= g_byte_nxt;
    for (int j = 0; j < 3; j++) begin
      g_mag_r[j] <= m_mag_r[j];
    end
  end

  // ------------------------------------------- leading bit: within group
  logic          k_vld_r;
  logic          k_degen_r;
  logic [2:0]    k_neg_r;
  logic [MW-1:0] k_mag_r [3];
  logic [KW-1:0] k_len_r;
  logic [KW-1:0] k_len_nxt;

  always_comb begin
    k_len_nxt = '0;
    for (int i = 0; i < 8; i++) begin
      if (g_byte_r[i]) begin
        k_len_nxt = KW'({g_sel_r, 3'(i)}) + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_vld_r <= 1'b0;
    end else begin
      k_vld_r <= g_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    k_degen_r <= g_degen_r;
    k_neg_r   <= g_neg_r;
    k_len_r   <= k_len_nxt;
    for (int j = 0; j < 3; j++) begin
      k_mag_r[j] <= g_mag_r[j];
    end
  end

  // ------------------------------------------ normalize to 30-bit leader
  logic              n_vld_r;
  tfn_pkg::norm_tag_t n_tag_r;
  tfn_pkg::norm_tag_t n_tag_nxt;

  always_comb begin
    logic [XW-1:0] ext;
    logic [XW-1:0] sh;
    n_tag_nxt.degen = k_degen_r;
    n_tag_nxt.neg   = k_neg_r;
    for (int j = 0; j < 3; j++) begin
      ext = XW'(k_mag_r[j]);
      if (k_len_r > KW'(NB)) begin
        sh = ext >> (k_len_r - KW'(NB));
      end else begin
        sh = ext << (KW'(NB) - k_len_r);
      end
      n_tag_nxt.mag[j] = sh[NB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_vld_r <= 1'b0;
    end else begin
      n_vld_r <= k_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    n_tag_r <= n_tag_nxt;
  end

  // -------------------------------------------------------------- squares
  logic                         q_vld_r;
  tfn_pkg::norm_tag_t           q_tag_r;
  logic [tfn_pkg::SQ_W-1:0]     q_sq_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r <= 1'b0;
    end else begin
      q_vld_r <= n_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    q_tag_r <= n_tag_r;
    for (int j = 0; j < 3; j++) begin
      q_sq_r[j] <= n_tag_r.mag[j] * n_tag_r.mag[j];
    end
  end

  // ------------------------------------------- square root, one bit/stage
  // Stage 0 holds the sum of squares; stage i+1 decides root bit RW-1-i.
  logic               sr_vld_r  [RW+1];
  tfn_pkg::norm_tag_t sr_tag_r  [RW+1];
  logic [SW-1:0]      sr_rem_r  [RW+1];
  logic [RW-1:0]      sr_root_r [RW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_vld_r[0] <= 1'b0;
    end else begin
      sr_vld_r[0] <= q_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sr_tag_r[0]  <= q_tag_r;
    sr_rem_r[0]  <= SW'(q_sq_r[0]) + SW'(q_sq_r[1]) + SW'(q_sq_r[2]);
    sr_root_r[0] <= '0;
  end

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    localparam int P = RW - 1 - i;
    logic [63:0]   trial;
    logic          take;
    logic [63:0]   diff;

    // trial = (root + 2^P)^2 - root^2 with root's low P+1 bits clear
    always_comb begin
      trial = (64'(sr_root_r[i]) << (P + 1)) + (64'd1 << (2 * P));
      take  = 64'(sr_rem_r[i]) >= trial;
      diff  = 64'(sr_rem_r[i]) - trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sr_vld_r[i+1] <= 1'b0;
      end else begin
        sr_vld_r[i+1] <= sr_vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      sr_tag_r[i+1] <= sr_tag_r[i];
      if (take) begin
        sr_rem_r[i+1]  <= diff[SW-1:0];
        sr_root_r[i+1] <= sr_root_r[i] | (RW'(1) << P);
      end else begin
        sr_rem_r[i+1]  <= sr_rem_r[i];
        sr_root_r[i+1] <= sr_root_r[i];
      end
    end
  end

  // ------------------------------------------- divide, one bit/stage
  // Stage 0 holds m*2^14 + floor(len/2); stage j+1 decides quotient bit QW-1-j.
  logic               dv_vld_r [QW+1];
  tfn_pkg::sign_tag_t dv_tag_r [QW+1];
  logic [RW-1:0]      dv_len_r [QW+1];
  logic [NW-1:0]      dv_rem_r [QW+1][3];
  logic [QW-1:0]      dv_quo_r [QW+1][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else begin
      dv_vld_r[0] <= sr_vld_r[RW];
    end
  end

  always_ff @(posedge clk) begin
    dv_tag_r[0].degen <= sr_tag_r[RW].degen;
    dv_tag_r[0].neg   <= sr_tag_r[RW].neg;
    dv_len_r[0]       <= sr_root_r[RW];
    for (int l = 0; l < 3; l++) begin
      dv_rem_r[0][l] <= (NW'(sr_tag_r[RW].mag[l]) << tfn_pkg::FRAC_OUT)
                        + NW'(sr_root_r[RW] >> 1);
      dv_quo_r[0][l] <= '0;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int P = QW - 1 - j;
    logic [NW:0] dvs;

    assign dvs = (NW+1)'(dv_len_r[j]) << P;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[j+1] <= 1'b0;
      end else begin
        dv_vld_r[j+1] <= dv_vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      logic [NW:0] d;
      dv_tag_r[j+1] <= dv_tag_r[j];
      dv_len_r[j+1] <= dv_len_r[j];
      for (int l = 0; l < 3; l++) begin
        d = (NW+1)'(dv_rem_r[j][l]) - dvs;
        if ((NW+1)'(dv_rem_r[j][l]) >= dvs) begin
          dv_rem_r[j+1][l] <= d[NW-1:0];
          dv_quo_r[j+1][l] <= dv_quo_r[j][l] | (QW'(1) << P);
        end else begin
          dv_rem_r[j+1][l] <= dv_rem_r[j][l];
          dv_quo_r[j+1][l] <= dv_quo_r[j][l];
        end
      end
    end
  end

  // --------------------------------------------------- sign and output beat
  logic [OW-1:0] o_nrm_nxt [3];

  always_comb begin
    logic [OW-1:0] qx;
    for (int l = 0; l < 3; l++) begin
      qx = OW'(dv_quo_r[QW][l]);
      if (dv_tag_r[QW].degen) begin
        o_nrm_nxt[l] = '0;
      end else if (dv_tag_r[QW].neg[l]) begin
        o_nrm_nxt[l] = ~qx + OW'(1);
      end else begin
        o_nrm_nxt[l] = qx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_vld_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    out_normal_x   <= o_nrm_nxt[0];
    out_normal_y   <= o_nrm_nxt[1];
    out_normal_z   <= o_nrm_nxt[2];
    out_degenerate <= dv_tag_r[QW].degen;
  end

  // ------------------------------------------------------------ assertions
  // a zero-area beat must reach normalization with all magnitudes zero
  a_degen_zero_mag: assert property (@(posedge clk) disable iff (!rst_n)
    n_vld_r && n_tag_r.degen |->
      (n_tag_r.mag[0] == '0) && (n_tag_r.mag[1] == '0) && (n_tag_r.mag[2] == '0))
    else $error("degenerate beat with nonzero normalized magnitude");

  // after normalization the largest magnitude has its top bit set
  a_norm_leader: assert property (@(posedge clk) disable iff (!rst_n)
    n_vld_r && !n_tag_r.degen |->
      (n_tag_r.mag[0][NB-1] || n_tag_r.mag[1][NB-1] || n_tag_r.mag[2][NB-1]))
    else $error("normalization missed the leading bit");

  // root of a normalized sum is at least 2^(NB-1)
  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    sr_vld_r[RW] && !sr_tag_r[RW].degen |-> (sr_root_r[RW][RW-1:NB-1] != '0))
    else $error("square root below normalized range");

  // quotient never exceeds one in Q1.14 (zero-area beats divide by zero)
  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld_r[QW] && !dv_tag_r[QW].degen |->
      (dv_quo_r[QW][0] <= QW'(16384)) && (dv_quo_r[QW][1] <= QW'(16384)) &&
      (dv_quo_r[QW][2] <= QW'(16384)))
    else $error("normal component above unit length");

  // a degenerate result carries a zero vector
  a_out_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      (out_normal_x == '0) && (out_normal_y == '0) && (out_normal_z == '0))
    else $error("degenerate result with nonzero normal");

endmodule
